/* sv/ngeg_pkg.sv */
// Shared types and constants of the normalized Gegenbauer evaluator.
`default_nettype none
package ngeg_pkg;

  localparam int unsigned DEG_W    = 6;
  localparam int unsigned X_W      = 32;
  localparam int unsigned BASE_W   = 31;
  localparam int unsigned VAL_W    = 48;
  localparam int unsigned FAC_W    = 8;
  localparam int unsigned PQ_W     = 24;
  localparam int unsigned DIV_FRAC = 58;
  localparam int unsigned SQ_STEPS = 32;
  localparam int unsigned ROOT_W   = 32;
  localparam int unsigned OPND_W   = 64;
  localparam int unsigned PROD_W   = 128;
  localparam int unsigned SH_INIT  = 27;
  localparam int unsigned SH_RAISE = 29;
  localparam int unsigned SH_TERM  = 59;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_ORDER = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    CMD_NONE    = 4'd0,
    CMD_LOAD    = 4'd1,
    CMD_PQ1     = 4'd2,
    CMD_PQ2     = 4'd3,
    CMD_ROOT_GO = 4'd4,
    CMD_MUL_GO  = 4'd5,
    CMD_MUL_WB  = 4'd6,
    CMD_INC_I   = 4'd7,
    CMD_RESET_I = 4'd8,
    CMD_SUM     = 4'd9,
    CMD_OUT     = 4'd10
  } cmd_t;

  typedef enum logic [1:0] {
    K_R0 = 2'd0,
    K_R1 = 2'd1,
    K_A  = 2'd2,
    K_B  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    M_N1I = 3'd0,
    M_N0  = 3'd1,
    M_N1  = 3'd2,
    M_XA  = 3'd3,
    M_T1  = 3'd4,
    M_T2  = 3'd5
  } msel_t;

  typedef enum logic [1:0] {
    O_ZERO = 2'd0,
    O_N0   = 2'd1,
    O_N1   = 2'd2
  } osrc_t;

  typedef struct packed {
    cmd_t  cmd;
    kind_t kind;
    msel_t sel;
    osrc_t src;
  } ctl_t;

  typedef struct packed {
    logic st_bad;
    logic raise_done;
    logic l_zero;
    logic l_one;
    logic rec_done;
    logic root_done;
    logic mul_done;
  } flags_t;

endpackage
`default_nettype wire

/* sv/ngeg_root.sv */
// Iterative unit computing floor(sqrt(floor(num * 2^58 / den))).
`default_nettype none
module ngeg_root (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [ngeg_pkg::PQ_W-1:0]   num,
  input  wire logic [ngeg_pkg::PQ_W-1:0]   den,
  output logic                              done,
  output logic [ngeg_pkg::ROOT_W-1:0]      res
);
  import ngeg_pkg::*;

  localparam int unsigned DVD_W     = PQ_W + DIV_FRAC;
  localparam int unsigned DIV_STEPS = DVD_W;

  typedef enum logic [2:0] {
    R_IDLE = 3'b001,
    R_DIV  = 3'b010,
    R_SQRT = 3'b100
  } rphase_t;

  rphase_t           ph_r, ph_nxt;
  logic [6:0]        cnt_r, cnt_nxt;
  logic [DVD_W-1:0]  dvd_r, dvd_nxt;
  logic [PQ_W-1:0]   den_r, den_nxt;
  logic [PQ_W-1:0]   rem_r, rem_nxt;
  logic [63:0]       acc_r, acc_nxt;
  logic [63:0]       res_r, res_nxt;
  logic [63:0]       bit_r, bit_nxt;
  logic              done_r, done_nxt;

  logic [PQ_W:0]     trial;
  logic [PQ_W:0]     diff;
  logic              take;
  logic [63:0]       sq_t;
  logic              sq_take;

  assign trial   = {rem_r, dvd_r[DVD_W-1]};
  assign diff    = trial - {1'b0, den_r};
  assign take    = trial >= {1'b0, den_r};
  assign sq_t    = res_r + bit_r;
  assign sq_take = acc_r >= sq_t;

  always_comb begin
    ph_nxt   = ph_r;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    acc_nxt  = acc_r;
    res_nxt  = res_r;
    bit_nxt  = bit_r;
    done_nxt = 1'b0;
    unique case (ph_r)
      R_IDLE: begin
        if (start) begin
          dvd_nxt = {num, {DIV_FRAC{1'b0}}};
          den_nxt = den;
          rem_nxt = '0;
          acc_nxt = '0;
          cnt_nxt = '0;
          ph_nxt  = R_DIV;
        end
      end
      R_DIV: begin
        rem_nxt = take ? diff[PQ_W-1:0] : trial[PQ_W-1:0];
        acc_nxt = {acc_r[62:0], take};
        dvd_nxt = {dvd_r[DVD_W-2:0], 1'b0};
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == 7'(DIV_STEPS - 1)) begin
          ph_nxt  = R_SQRT;
          res_nxt = '0;
          bit_nxt = 64'h1 << 62;
          cnt_nxt = '0;
        end
      end
      R_SQRT: begin
        if (sq_take) begin
          acc_nxt = acc_r - sq_t;
          res_nxt = (res_r >> 1) + bit_r;
        end else begin
          res_nxt = res_r >> 1;
        end
        bit_nxt = bit_r >> 2;
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == 7'(SQ_STEPS - 1)) begin
          ph_nxt   = R_IDLE;
          done_nxt = 1'b1;
        end
      end
      default: ph_nxt = R_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= R_IDLE;
      done_r <= 1'b0;
    end else begin
      ph_r   <= ph_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    dvd_r <= dvd_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
    acc_r <= acc_nxt;
    res_r <= res_nxt;
    bit_r <= bit_nxt;
  end

  assign done = done_r;
  assign res  = res_r[ROOT_W-1:0];

endmodule
`default_nettype wire

/* sv/ngeg_mul.sv */
// Multicycle 64 by 64 bit unsigned multiplier built from 32 by 32 bit partial products.
`default_nettype none
module ngeg_mul (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [ngeg_pkg::OPND_W-1:0] a,
  input  wire logic [ngeg_pkg::OPND_W-1:0] b,
  output logic                             done,
  output logic [ngeg_pkg::PROD_W-1:0]      prod
);
  import ngeg_pkg::*;

  localparam logic [2:0] MUL_PARTS = 3'd4;

  logic [OPND_W-1:0] a_r, a_nxt;
  logic [OPND_W-1:0] b_r, b_nxt;
  logic [PROD_W-1:0] acc_r, acc_nxt;
  logic [2:0]        cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic [63:0]       pp_r, pp_nxt;
  logic [1:0]        psh_r, psh_nxt;
  logic              ppv_r, ppv_nxt;
  logic              done_r, done_nxt;

  logic              ka, kb;
  logic [31:0]       ah, bh;
  logic [63:0]       pp_new;
  logic [PROD_W-1:0] acc_add;

  assign ka      = cnt_r[1];
  assign kb      = cnt_r[0];
  assign ah      = ka ? a_r[63:32] : a_r[31:0];
  assign bh      = kb ? b_r[63:32] : b_r[31:0];
  assign pp_new  = 64'(ah) * 64'(bh);
  assign acc_add = acc_r + ({64'b0, pp_r} << {psh_r, 5'b0});

  always_comb begin
    a_nxt    = a_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    pp_nxt   = pp_r;
    psh_nxt  = psh_r;
    ppv_nxt  = ppv_r;
    done_nxt = 1'b0;
    if (start) begin
      a_nxt    = a;
      b_nxt    = b;
      acc_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
      ppv_nxt  = 1'b0;
    end else if (busy_r) begin
      if (cnt_r < MUL_PARTS) begin
        pp_nxt  = pp_new;
        psh_nxt = {1'b0, ka} + {1'b0, kb};
        ppv_nxt = 1'b1;
      end else begin
        ppv_nxt = 1'b0;
      end
      if (ppv_r) begin
        acc_nxt = acc_add;
      end
      cnt_nxt = cnt_r + 3'd1;
      if (cnt_r == MUL_PARTS) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ppv_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      ppv_r  <= ppv_nxt;
      done_r <= done_nxt;
    end
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
    cnt_r <= cnt_nxt;
    pp_r  <= pp_nxt;
    psh_r <= psh_nxt;
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule
`default_nettype wire

/* sv/ngeg_dp.sv */
// Datapath: operand registers, factor setup, root and multiply units, saturation and output.
`default_nettype none
module ngeg_dp #(
  parameter int unsigned MAX_DEGREE = 63
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_we,
  input  wire logic [ngeg_pkg::BASE_W-1:0]       cfg_wdata,
  input  wire logic [ngeg_pkg::DEG_W-1:0]        in_degree,
  input  wire logic [ngeg_pkg::DEG_W-1:0]        in_order,
  input  wire logic signed [ngeg_pkg::X_W-1:0]   in_arg,
  input  wire ngeg_pkg::ctl_t                    ctl,
  output ngeg_pkg::flags_t                       flags,
  output logic signed [ngeg_pkg::VAL_W-1:0]      out_value,
  output logic [1:0]                             out_status
);
  import ngeg_pkg::*;

  localparam int unsigned DEG_CAP = (MAX_DEGREE < 63) ? MAX_DEGREE : 63;
  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic signed [X_W-1:0]   X_ONE   = 32'sh40000000;

  logic [BASE_W-1:0]       base_r;
  logic [DEG_W-1:0]        l_r, m_r;
  logic signed [X_W-1:0]   x_r;
  status_t                 st_r;
  logic [DEG_W:0]          i_r;
  logic signed [VAL_W-1:0] n0_r, n1_r, t1_r, t2_r;
  logic [OPND_W-1:0]       xam_r;
  logic                    xneg_r;
  logic                    mneg_r;
  logic [2*FAC_W-1:0]      np1_r, dp1_r;
  logic [PQ_W-1:0]         num_r, den_r;
  logic signed [VAL_W-1:0] value_r;
  status_t                 status_r;

  logic [DEG_W-1:0]        l_eff;
  status_t                 st_new;
  logic [FAC_W-1:0]        iw, mw;
  logic [FAC_W-1:0]        f1, f2, f3, d1, d2, d3;
  logic [X_W:0]            xmag;
  logic [VAL_W-1:0]        n0mag, n1mag;
  logic [OPND_W-1:0]       mul_a, mul_b;
  logic                    mul_neg;
  logic                    mul_done;
  logic [PROD_W-1:0]       mul_prod;
  logic [PROD_W-1:0]       shifted;
  logic [6:0]              sh_amt;
  logic signed [VAL_W-1:0] sat_res;
  logic signed [VAL_W:0]   sum_w;
  logic signed [VAL_W-1:0] sum_sat;
  logic                    root_done;
  logic [ROOT_W-1:0]       root_res;

  function automatic logic signed [VAL_W-1:0] sat_mag(input logic neg,
                                                     input logic [PROD_W-1:0] mag);
    logic signed [VAL_W-1:0] r;
    if (neg) begin
      if (mag > PROD_W'(VAL_MIN[VAL_W-1:0])) r = VAL_MIN;
      else r = -$signed(mag[VAL_W-1:0]);
    end else begin
      if (mag > PROD_W'(VAL_MAX)) r = VAL_MAX;
      else r = $signed(mag[VAL_W-1:0]);
    end
    return r;
  endfunction

  assign l_eff = (in_degree > DEG_W'(DEG_CAP)) ? DEG_W'(DEG_CAP) : in_degree;

  always_comb begin
    if ((in_arg > X_ONE) || (in_arg < -X_ONE)) st_new = ST_RANGE;
    else if (in_order == '0) st_new = ST_ORDER;
    else st_new = ST_OK;
  end

  assign iw = FAC_W'(i_r);
  assign mw = FAC_W'(m_r);

  always_comb begin
    f2 = FAC_W'(1);
    f3 = FAC_W'(1);
    d2 = FAC_W'(1);
    d3 = FAC_W'(1);
    unique case (ctl.kind)
      K_R0: begin
        f1 = {iw[FAC_W-2:0], 1'b0};
        d1 = {iw[FAC_W-2:0], 1'b0} - FAC_W'(1);
      end
      K_R1: begin
        f1 = {iw[FAC_W-2:0], 1'b0} + FAC_W'(2);
        d1 = {iw[FAC_W-2:0], 1'b0} - FAC_W'(1);
      end
      K_A: begin
        f1 = iw + mw;
        f2 = iw + mw - FAC_W'(1);
        d1 = iw;
        d2 = iw + {mw[FAC_W-2:0], 1'b0} - FAC_W'(1);
      end
      K_B: begin
        f1 = iw - FAC_W'(1);
        f2 = iw + mw;
        f3 = iw + {mw[FAC_W-2:0], 1'b0} - FAC_W'(2);
        d1 = iw;
        d2 = iw + mw - FAC_W'(2);
        d3 = iw + {mw[FAC_W-2:0], 1'b0} - FAC_W'(1);
      end
      default: begin
        f1 = '0;
        d1 = '0;
      end
    endcase
  end

  assign xmag  = x_r[X_W-1] ? (X_W+1)'(-{x_r[X_W-1], x_r}) : {1'b0, x_r};
  assign n0mag = n0_r[VAL_W-1] ? VAL_W'(-n0_r) : VAL_W'(n0_r);
  assign n1mag = n1_r[VAL_W-1] ? VAL_W'(-n1_r) : VAL_W'(n1_r);

  always_comb begin
    unique case (ctl.sel)
      M_N1I: begin
        mul_a   = OPND_W'(xmag);
        mul_b   = OPND_W'(base_r);
        mul_neg = x_r[X_W-1];
      end
      M_N0: begin
        mul_a   = OPND_W'(n0mag);
        mul_b   = OPND_W'(root_res);
        mul_neg = n0_r[VAL_W-1];
      end
      M_N1: begin
        mul_a   = OPND_W'(n1mag);
        mul_b   = OPND_W'(root_res);
        mul_neg = n1_r[VAL_W-1];
      end
      M_XA: begin
        mul_a   = OPND_W'(xmag);
        mul_b   = OPND_W'({root_res, 1'b0});
        mul_neg = x_r[X_W-1];
      end
      M_T1: begin
        mul_a   = OPND_W'(n1mag);
        mul_b   = xam_r;
        mul_neg = xneg_r ^ n1_r[VAL_W-1];
      end
      M_T2: begin
        mul_a   = OPND_W'(n0mag);
        mul_b   = OPND_W'(root_res);
        mul_neg = !n0_r[VAL_W-1];
      end
      default: begin
        mul_a   = '0;
        mul_b   = '0;
        mul_neg = 1'b0;
      end
    endcase
  end

  always_comb begin
    case (ctl.sel)
      M_N1I:   sh_amt = 7'(SH_INIT);
      M_XA:    sh_amt = '0;
      M_T1:    sh_amt = 7'(SH_TERM);
      default: sh_amt = 7'(SH_RAISE);
    endcase
  end

  assign shifted = mul_prod >> sh_amt;
  assign sat_res = sat_mag(mneg_r, shifted);
  assign sum_w   = {t1_r[VAL_W-1], t1_r} + {t2_r[VAL_W-1], t2_r};
  assign sum_sat = (sum_w[VAL_W] != sum_w[VAL_W-1]) ?
                   (sum_w[VAL_W] ? VAL_MIN : VAL_MAX) : sum_w[VAL_W-1:0];

  ngeg_root u_root (
    .clk   (clk),
    .rst_n (rst_n),
    .start (ctl.cmd == CMD_ROOT_GO),
    .num   (num_r),
    .den   (den_r),
    .done  (root_done),
    .res   (root_res)
  );

  ngeg_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (ctl.cmd == CMD_MUL_GO),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= BASE_W'(32'h40000000);
    end else if (cfg_we) begin
      base_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    case (ctl.cmd)
      CMD_LOAD: begin
        l_r  <= l_eff;
        m_r  <= in_order;
        x_r  <= in_arg;
        st_r <= st_new;
        i_r  <= (DEG_W+1)'(2);
        n0_r <= $signed(VAL_W'({base_r, 2'b00}));
      end
      CMD_PQ1: begin
        np1_r <= (2*FAC_W)'(f1) * (2*FAC_W)'(f2);
        dp1_r <= (2*FAC_W)'(d1) * (2*FAC_W)'(d2);
      end
      CMD_PQ2: begin
        num_r <= PQ_W'(np1_r) * PQ_W'(f3);
        den_r <= PQ_W'(dp1_r) * PQ_W'(d3);
      end
      CMD_MUL_GO: begin
        mneg_r <= mul_neg;
      end
      CMD_MUL_WB: begin
        case (ctl.sel)
          M_N1I, M_N1: n1_r <= sat_res;
          M_N0:        n0_r <= sat_res;
          M_XA: begin
            xam_r  <= mul_prod[OPND_W-1:0];
            xneg_r <= mneg_r;
          end
          M_T1:        t1_r <= sat_res;
          M_T2:        t2_r <= sat_res;
          default: ;
        endcase
      end
      CMD_INC_I:   i_r <= i_r + (DEG_W+1)'(1);
      CMD_RESET_I: i_r <= (DEG_W+1)'(2);
      CMD_SUM: begin
        n0_r <= n1_r;
        n1_r <= sum_sat;
        i_r  <= i_r + (DEG_W+1)'(1);
      end
      CMD_OUT: begin
        case (ctl.src)
          O_N0:    value_r <= n0_r;
          O_N1:    value_r <= n1_r;
          default: value_r <= '0;
        endcase
        status_r <= st_r;
      end
      default: ;
    endcase
  end

  assign flags.st_bad     = (st_r != ST_OK);
  assign flags.raise_done = (i_r > {1'b0, m_r});
  assign flags.rec_done   = (i_r > {1'b0, l_r});
  assign flags.l_zero     = (l_r == DEG_W'(0));
  assign flags.l_one      = (l_r == DEG_W'(1));
  assign flags.root_done  = root_done;
  assign flags.mul_done   = mul_done;

  assign out_value  = value_r;
  assign out_status = status_r;

endmodule
`default_nettype wire

/* sv/ngeg_ctrl.sv */
// Controller state machine sequencing the evaluator datapath.
`default_nettype none
module ngeg_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  input  wire ngeg_pkg::flags_t flags,
  output ngeg_pkg::ctl_t        ctl
);
  import ngeg_pkg::*;

  typedef enum logic [14:0] {
    S_IDLE  = 15'h0001,
    S_CHECK = 15'h0002,
    S_RTEST = 15'h0004,
    S_DTEST = 15'h0008,
    S_CTEST = 15'h0010,
    S_PQ1   = 15'h0020,
    S_PQ2   = 15'h0040,
    S_RGO   = 15'h0080,
    S_RWAIT = 15'h0100,
    S_MGO   = 15'h0200,
    S_MWAIT = 15'h0400,
    S_MWB   = 15'h0800,
    S_SUM   = 15'h1000,
    S_NEXTI = 15'h2000,
    S_OUT   = 15'h4000
  } state_t;

  state_t state_r, state_nxt;
  kind_t  kind_r, kind_nxt;
  msel_t  sel_r, sel_nxt;
  osrc_t  src_r, src_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    sel_nxt       = sel_r;
    src_nxt       = src_r;
    out_valid_nxt = out_valid_r && !out_ready;
    ctl.cmd       = CMD_NONE;
    ctl.kind      = kind_r;
    ctl.sel       = sel_r;
    ctl.src       = src_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ctl.cmd   = CMD_LOAD;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (flags.st_bad) begin
          src_nxt   = O_ZERO;
          state_nxt = S_OUT;
        end else begin
          sel_nxt   = M_N1I;
          state_nxt = S_MGO;
        end
      end
      S_RTEST: begin
        if (flags.raise_done) begin
          state_nxt = S_DTEST;
        end else begin
          kind_nxt  = K_R0;
          state_nxt = S_PQ1;
        end
      end
      S_DTEST: begin
        if (flags.l_zero) begin
          src_nxt   = O_N0;
          state_nxt = S_OUT;
        end else if (flags.l_one) begin
          src_nxt   = O_N1;
          state_nxt = S_OUT;
        end else begin
          ctl.cmd   = CMD_RESET_I;
          state_nxt = S_CTEST;
        end
      end
      S_CTEST: begin
        if (flags.rec_done) begin
          src_nxt   = O_N1;
          state_nxt = S_OUT;
        end else begin
          kind_nxt  = K_A;
          state_nxt = S_PQ1;
        end
      end
      S_PQ1: begin
        ctl.cmd   = CMD_PQ1;
        state_nxt = S_PQ2;
      end
      S_PQ2: begin
        ctl.cmd   = CMD_PQ2;
        state_nxt = S_RGO;
      end
      S_RGO: begin
        ctl.cmd   = CMD_ROOT_GO;
        state_nxt = S_RWAIT;
      end
      S_RWAIT: begin
        if (flags.root_done) begin
          unique case (kind_r)
            K_R0:    sel_nxt = M_N0;
            K_R1:    sel_nxt = M_N1;
            K_A:     sel_nxt = M_XA;
            default: sel_nxt = M_T2;
          endcase
          state_nxt = S_MGO;
        end
      end
      S_MGO: begin
        ctl.cmd   = CMD_MUL_GO;
        state_nxt = S_MWAIT;
      end
      S_MWAIT: begin
        if (flags.mul_done) begin
          state_nxt = S_MWB;
        end
      end
      S_MWB: begin
        ctl.cmd = CMD_MUL_WB;
        unique case (sel_r)
          M_N1I: state_nxt = S_RTEST;
          M_N0: begin
            kind_nxt  = K_R1;
            state_nxt = S_PQ1;
          end
          M_N1: state_nxt = S_NEXTI;
          M_XA: begin
            sel_nxt   = M_T1;
            state_nxt = S_MGO;
          end
          M_T1: begin
            kind_nxt  = K_B;
            state_nxt = S_PQ1;
          end
          M_T2:    state_nxt = S_SUM;
          default: state_nxt = S_IDLE;
        endcase
      end
      S_SUM: begin
        ctl.cmd   = CMD_SUM;
        state_nxt = S_CTEST;
      end
      S_NEXTI: begin
        ctl.cmd   = CMD_INC_I;
        state_nxt = S_RTEST;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          ctl.cmd       = CMD_OUT;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      kind_r      <= K_R0;
      sel_r       <= M_N1I;
      src_r       <= O_ZERO;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      kind_r      <= kind_nxt;
      sel_r       <= sel_nxt;
      src_r       <= src_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

/* sv/normalized_gegenbauer_eval.sv */
// Top level of the normalized Gegenbauer evaluator.
// One transaction at a time; a rejected input goes from the check state straight to output.
// Otherwise the time is set by the bit-serial divide and square root of the shared root unit,
// two per step, plus 4-part multiplies; degree 0 or 1 skips the recurrence steps.
// A waiting result does not block input.
// Synchronous active-low reset clears the controller and sets base_scale to 1.0.
`default_nettype none
module normalized_gegenbauer_eval #(
  parameter int unsigned MAX_DEGREE = 63
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [ngeg_pkg::DEG_W-1:0]      in_degree,
  input  wire logic [ngeg_pkg::DEG_W-1:0]      in_order,
  input  wire logic signed [ngeg_pkg::X_W-1:0] in_arg,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic signed [ngeg_pkg::VAL_W-1:0]    out_value,
  output logic [1:0]                            out_status,
  input  wire logic                             cfg_we,
  input  wire logic [ngeg_pkg::BASE_W-1:0]     cfg_wdata
);
  import ngeg_pkg::*;

  ctl_t   ctl;
  flags_t flags;

  ngeg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .flags     (flags),
    .ctl       (ctl)
  );

  ngeg_dp #(
    .MAX_DEGREE (MAX_DEGREE)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_degree  (in_degree),
    .in_order   (in_order),
    .in_arg     (in_arg),
    .ctl        (ctl),
    .flags      (flags),
    .out_value  (out_value),
    .out_status (out_status)
  );

`ifndef ASSERT_OFF
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK || out_status == ST_RANGE || out_status == ST_ORDER))
    else $error("result status code out of range");

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> (out_value == '0))
    else $error("rejected transaction carries a nonzero value");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while a transaction is in progress");
`endif

endmodule
`default_nettype wire
